[sv/bamv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bamv_pkg
// shared types, constants and curve tables for the battery adc converter
// ----------------------------------------------------------------------------
package bamv_pkg;

   localparam int unsigned ADC_BITS_DEF = 12;
   localparam int unsigned CODE_W       = 12;
   localparam int unsigned MV_W         = 13;
   localparam int unsigned PCT_W        = 7;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 13;

   // divider geometry: |code delta| * mv span fits 23 bits under a good calibration
   localparam int unsigned DIV_NUM_W = 23;
   localparam int unsigned DIV_DEN_W = 12;

   // calibration limits
   localparam logic [CODE_W-1:0] CAL_CODE_MIN = 12'd50;
   localparam logic [CODE_W:0]   CAL_CODE_GAP = 13'd20;
   localparam logic [MV_W-1:0]   CAL_MV_MIN   = 13'd2500;
   localparam logic [MV_W-1:0]   CAL_MV_MAX   = 13'd4500;
   localparam logic [MV_W:0]     CAL_MV_GAP   = 14'd100;
   localparam logic [MV_W-1:0]   MV_CLAMP     = 13'd5000;

   // charge curve
   localparam logic [MV_W-1:0]  CURVE_MV_LO = 13'd3300;
   localparam logic [MV_W-1:0]  CURVE_MV_HI = 13'd4200;
   localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;
   localparam int unsigned      SEG_CNT     = 9;
   localparam int unsigned      RECIP_SHIFT = 20;
   localparam int unsigned      OFF_W       = 8;
   localparam int unsigned      DP_W        = 4;
   localparam int unsigned      RECIP_W     = 15;
   localparam int unsigned      PROD_W      = OFF_W + DP_W;
   localparam int unsigned      FRAC_W      = 4;

   typedef logic [3:0] seg_idx_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_CAL_CODE_LOW  = 3'd0,
      REG_CAL_CODE_MID  = 3'd1,
      REG_CAL_CODE_HIGH = 3'd2,
      REG_CAL_MV_LOW    = 3'd3,
      REG_CAL_MV_MID    = 3'd4,
      REG_CAL_MV_HIGH   = 3'd5
   } csr_idx_type;

   // sideband that rides along the divider
   typedef struct packed {
      logic            ok;
      logic            neg;
      logic [MV_W-1:0] m0;
   } div_side_type;

   // lower knee of each curve segment
   function automatic logic [MV_W-1:0] seg_base_mv(input seg_idx_type idx);
      logic [MV_W-1:0] r;
      unique case (idx)
         4'd0:    r = 13'd3300;
         4'd1:    r = 13'd3500;
         4'd2:    r = 13'd3650;
         4'd3:    r = 13'd3700;
         4'd4:    r = 13'd3750;
         4'd5:    r = 13'd3800;
         4'd6:    r = 13'd3900;
         4'd7:    r = 13'd4000;
         4'd8:    r = 13'd4100;
         default: r = 13'd4200;
      endcase
      return r;
   endfunction

   function automatic logic [PCT_W-1:0] seg_base_pct(input seg_idx_type idx);
      logic [PCT_W-1:0] r;
      unique case (idx)
         4'd0:    r = 7'd0;
         4'd1:    r = 7'd5;
         4'd2:    r = 7'd15;
         4'd3:    r = 7'd25;
         4'd4:    r = 7'd40;
         4'd5:    r = 7'd55;
         4'd6:    r = 7'd70;
         4'd7:    r = 7'd80;
         4'd8:    r = 7'd90;
         default: r = 7'd100;
      endcase
      return r;
   endfunction

   // percent rise over the segment
   function automatic logic [DP_W-1:0] seg_dp(input seg_idx_type idx);
      logic [DP_W-1:0] r;
      unique case (idx)
         4'd0:    r = 4'd5;
         4'd1:    r = 4'd10;
         4'd2:    r = 4'd10;
         4'd3:    r = 4'd15;
         4'd4:    r = 4'd15;
         4'd5:    r = 4'd15;
         4'd6:    r = 4'd10;
         4'd7:    r = 4'd10;
         4'd8:    r = 4'd10;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   // ceil(2^20 / segment mv span), exact for numerators below 4096
   function automatic logic [RECIP_W-1:0] seg_recip(input seg_idx_type idx);
      logic [RECIP_W-1:0] r;
      unique case (idx)
         4'd0:    r = 15'd5243;
         4'd1:    r = 15'd6991;
         4'd2:    r = 15'd20972;
         4'd3:    r = 15'd20972;
         4'd4:    r = 15'd20972;
         4'd5:    r = 15'd10486;
         4'd6:    r = 15'd10486;
         4'd7:    r = 15'd10486;
         4'd8:    r = 15'd10486;
         default: r = 15'd0;
      endcase
      return r;
   endfunction

endpackage

[sv/bamv_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bamv_div
// pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
module bamv_div #(
   parameter int unsigned NUM_W = bamv_pkg::DIV_NUM_W,
   parameter int unsigned DEN_W = bamv_pkg::DIV_DEN_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  logic [NUM_W-1:0]       in_num,
   input  logic [DEN_W-1:0]       in_den,
   input  bamv_pkg::div_side_type in_side,
   output logic                   out_valid,
   input  logic                   out_stall,
   output logic [NUM_W-1:0]       out_quo,
   output bamv_pkg::div_side_type out_side
);

   logic                   v_ff    [NUM_W];
   logic [DEN_W-1:0]       rem_ff  [NUM_W];
   logic [NUM_W-1:0]       num_ff  [NUM_W];
   logic [DEN_W-1:0]       den_ff  [NUM_W];
   bamv_pkg::div_side_type side_ff [NUM_W];

   logic                   en      [NUM_W];
   logic                   v_in    [NUM_W];
   logic [DEN_W-1:0]       rem_in  [NUM_W];
   logic [NUM_W-1:0]       num_in  [NUM_W];
   logic [DEN_W-1:0]       den_in  [NUM_W];
   bamv_pkg::div_side_type side_in [NUM_W];

   // a stage moves when it is empty or its successor moves
   always_comb begin
      en[NUM_W-1] = !v_ff[NUM_W-1] || !out_stall;
      for (int k = NUM_W - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      logic [DEN_W-1:0] p_rem;
      logic [NUM_W-1:0] p_num;
      logic [DEN_W:0]   trial;
      p_rem = '0;
      p_num = '0;
      trial = '0;
      for (int k = 0; k < NUM_W; k++) begin
         if (k == 0) begin
            v_in[k]    = in_valid;
            p_rem      = '0;
            p_num      = in_num;
            den_in[k]  = in_den;
            side_in[k] = in_side;
         end else begin
            v_in[k]    = v_ff[k-1];
            p_rem      = rem_ff[k-1];
            p_num      = num_ff[k-1];
            den_in[k]  = den_ff[k-1];
            side_in[k] = side_ff[k-1];
         end
         trial = {p_rem, p_num[NUM_W-1]};
         if (trial >= {1'b0, den_in[k]}) begin
            rem_in[k] = DEN_W'(trial - {1'b0, den_in[k]});
            num_in[k] = {p_num[NUM_W-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[DEN_W-1:0];
            num_in[k] = {p_num[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_W; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_W; k++) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            num_ff[k]  <= num_in[k];
            den_ff[k]  <= den_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign in_stall  = !en[0];
   assign out_valid = v_ff[NUM_W-1];
   assign out_quo   = num_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

[sv/battery_adc_to_mv_and_percent.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_adc_to_mv_and_percent
// adc code to millivolts (three-point calibration) and state-of-charge percent
// ----------------------------------------------------------------------------
// usage:
//   program the six calibration registers through csr_we / csr_addr /
//   csr_wdata while no beat is in flight, then stream adc codes on req_*.
//   every req beat yields exactly one rsp beat, in order.
// pipeline:
//   30 register stages: two front stages (segment pick, multiply), 23 divider
//   stages (one quotient bit each), five back stages (clamp, curve segment,
//   two constant multiplies, output). one beat per clock is sustained while
//   rsp_stall is low; the divider pipeline sets the depth.
// flow control:
//   each stage advances when empty or when the stage after it advances, so
//   bubbles close up and a new beat is taken while a result waits on a
//   stalled rsp channel, until the pipe is full. a stalled rsp beat holds.
// reset:
//   synchronous; empties the pipe and clears calibration to zero, which
//   fails the calibration check, so results read zero until programmed.
// ----------------------------------------------------------------------------
module battery_adc_to_mv_and_percent #(
   parameter int unsigned ADC_BITS = bamv_pkg::ADC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bamv_pkg::CODE_W-1:0]         req_adc_code,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_valid_res,
   output logic [bamv_pkg::MV_W-1:0]           rsp_millivolts,
   output logic [bamv_pkg::PCT_W-1:0]          rsp_charge_percent,
   // calibration write port
   input  logic                                csr_we,
   input  logic [bamv_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [bamv_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned CW = bamv_pkg::CODE_W;
   localparam int unsigned MW = bamv_pkg::MV_W;
   localparam int unsigned NW = bamv_pkg::DIV_NUM_W;
   localparam int unsigned DW = bamv_pkg::DIV_DEN_W;
   localparam int unsigned PW = bamv_pkg::PCT_W;
   localparam int unsigned BACK_N = 5;
   // largest code the converter can produce
   localparam logic [16:0] FullScale = 17'((1 << ADC_BITS) - 1);

   // ---------------------------------------------------------------- config
   logic [CW-1:0] code_low_ff, code_mid_ff, code_high_ff;
   logic [MW-1:0] mv_low_ff, mv_mid_ff, mv_high_ff;
   logic          cal_ok_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_low_ff  <= '0;
         code_mid_ff  <= '0;
         code_high_ff <= '0;
         mv_low_ff    <= '0;
         mv_mid_ff    <= '0;
         mv_high_ff   <= '0;
      end else if (csr_we) begin
         unique case (bamv_pkg::csr_idx_type'(csr_addr))
            bamv_pkg::REG_CAL_CODE_LOW:  code_low_ff  <= csr_wdata[CW-1:0];
            bamv_pkg::REG_CAL_CODE_MID:  code_mid_ff  <= csr_wdata[CW-1:0];
            bamv_pkg::REG_CAL_CODE_HIGH: code_high_ff <= csr_wdata[CW-1:0];
            bamv_pkg::REG_CAL_MV_LOW:    mv_low_ff    <= csr_wdata;
            bamv_pkg::REG_CAL_MV_MID:    mv_mid_ff    <= csr_wdata;
            bamv_pkg::REG_CAL_MV_HIGH:   mv_high_ff   <= csr_wdata;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // calibration check; the high code is always within 12 bits
   assign cal_ok_in = (code_low_ff >= bamv_pkg::CAL_CODE_MIN)
      && (({1'b0, code_low_ff} + bamv_pkg::CAL_CODE_GAP) < {1'b0, code_mid_ff})
      && (({1'b0, code_mid_ff} + bamv_pkg::CAL_CODE_GAP) < {1'b0, code_high_ff})
      && (mv_low_ff >= bamv_pkg::CAL_MV_MIN)
      && (mv_high_ff <= bamv_pkg::CAL_MV_MAX)
      && (({1'b0, mv_low_ff} + bamv_pkg::CAL_MV_GAP) < {1'b0, mv_mid_ff})
      && (({1'b0, mv_mid_ff} + bamv_pkg::CAL_MV_GAP) < {1'b0, mv_high_ff});

   // ---------------------------------------------------------------- front
   logic          f0_v_ff, f1_v_ff;
   logic          en_f0, en_f1;
   logic          div_in_stall;

   logic          f0_ok_ff, f0_neg_ff;
   logic [CW-1:0] f0_mag_ff;
   logic [DW-1:0] f0_den_ff;
   logic [MW-1:0] f0_dm_ff, f0_m0_ff;

   logic          f0_ok_in, f0_neg_in;
   logic [CW-1:0] f0_mag_in;
   logic [DW-1:0] f0_den_in;
   logic [MW-1:0] f0_dm_in, f0_m0_in;

   logic [NW-1:0]          f1_num_ff;
   logic [DW-1:0]          f1_den_ff;
   bamv_pkg::div_side_type f1_side_ff;
   logic [CW+MW-1:0]       f1_prod_in;

   assign en_f1     = !f1_v_ff || !div_in_stall;
   assign en_f0     = !f0_v_ff || en_f1;
   assign req_stall = !en_f0;

   // pick the segment, form |code - c0|, both spans and the base voltage
   always_comb begin
      logic          upper;
      logic [CW-1:0] c0, c1;
      logic [MW-1:0] m1;
      upper     = (req_adc_code >= code_mid_ff);
      c0        = upper ? code_mid_ff  : code_low_ff;
      c1        = upper ? code_high_ff : code_mid_ff;
      f0_m0_in  = upper ? mv_mid_ff    : mv_low_ff;
      m1        = upper ? mv_high_ff   : mv_mid_ff;
      f0_neg_in = (req_adc_code < c0);
      f0_mag_in = f0_neg_in ? (c0 - req_adc_code) : (req_adc_code - c0);
      f0_den_in = c1 - c0;
      f0_dm_in  = m1 - f0_m0_in;
      f0_ok_in  = cal_ok_in && ({5'b0, req_adc_code} <= FullScale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_v_ff <= 1'b0;
         f1_v_ff <= 1'b0;
      end else begin
         if (en_f0) begin
            f0_v_ff <= req_valid;
         end
         if (en_f1) begin
            f1_v_ff <= f0_v_ff;
         end
      end
   end

   assign f1_prod_in = (CW + MW)'(f0_mag_ff) * (CW + MW)'(f0_dm_ff);

   always_ff @(posedge clock) begin
      if (en_f0) begin
         f0_ok_ff  <= f0_ok_in;
         f0_neg_ff <= f0_neg_in;
         f0_mag_ff <= f0_mag_in;
         f0_den_ff <= f0_den_in;
         f0_dm_ff  <= f0_dm_in;
         f0_m0_ff  <= f0_m0_in;
      end
      if (en_f1) begin
         f1_num_ff       <= f1_prod_in[NW-1:0];
         f1_den_ff       <= f0_den_ff;
         f1_side_ff.ok   <= f0_ok_ff;
         f1_side_ff.neg  <= f0_neg_ff;
         f1_side_ff.m0   <= f0_m0_ff;
      end
   end

   // ---------------------------------------------------------------- divider
   logic                   div_out_valid;
   logic [NW-1:0]          div_quo;
   bamv_pkg::div_side_type div_side;

   // back stage handshake, the divider drains into it
   logic en_b   [BACK_N];
   logic b_v_ff [BACK_N];

   bamv_div #(
      .NUM_W (NW),
      .DEN_W (DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f1_v_ff),
      .in_stall  (div_in_stall),
      .in_num    (f1_num_ff),
      .in_den    (f1_den_ff),
      .in_side   (f1_side_ff),
      .out_valid (div_out_valid),
      .out_stall (!en_b[0]),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // ---------------------------------------------------------------- back
   always_comb begin
      en_b[BACK_N-1] = !b_v_ff[BACK_N-1] || !rsp_stall;
      for (int k = BACK_N - 2; k >= 0; k--) begin
         en_b[k] = !b_v_ff[k] || en_b[k+1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < BACK_N; k++) begin
         if (reset) begin
            b_v_ff[k] <= 1'b0;
         end else if (en_b[k]) begin
            b_v_ff[k] <= (k == 0) ? div_out_valid : b_v_ff[k-1];
         end
      end
   end

   // b0: apply quotient with sign, clamp to 0..5000
   logic          b0_ok_ff;
   logic [MW-1:0] b0_mv_ff;
   logic [MW-1:0] b0_mv_in;

   always_comb begin
      logic [NW:0] sum;
      sum = (NW + 1)'(div_side.m0) + (NW + 1)'(div_quo);
      if (!div_side.ok) begin
         b0_mv_in = '0;
      end else if (div_side.neg) begin
         // below the base: floor at zero
         if (div_quo > NW'(div_side.m0)) begin
            b0_mv_in = '0;
         end else begin
            b0_mv_in = div_side.m0 - div_quo[MW-1:0];
         end
      end else if (sum > (NW + 1)'(bamv_pkg::MV_CLAMP)) begin
         b0_mv_in = bamv_pkg::MV_CLAMP;
      end else begin
         b0_mv_in = sum[MW-1:0];
      end
   end

   // b1: find curve segment and offset into it
   logic                      b1_ok_ff, b1_lo_ff, b1_hi_ff;
   logic [MW-1:0]             b1_mv_ff;
   bamv_pkg::seg_idx_type     b1_idx_ff;
   logic [bamv_pkg::OFF_W-1:0] b1_off_ff;
   bamv_pkg::seg_idx_type     b1_idx_in;
   logic [MW-1:0]             b1_diff_in;

   always_comb begin
      b1_idx_in = '0;
      for (int i = 1; i < bamv_pkg::SEG_CNT; i++) begin
         if (b0_mv_ff >= bamv_pkg::seg_base_mv(bamv_pkg::seg_idx_type'(i))) begin
            b1_idx_in = bamv_pkg::seg_idx_type'(i);
         end
      end
      b1_diff_in = b0_mv_ff - bamv_pkg::seg_base_mv(b1_idx_in);
   end

   // b2: offset times percent rise
   logic                        b2_ok_ff, b2_lo_ff, b2_hi_ff;
   logic [MW-1:0]               b2_mv_ff;
   bamv_pkg::seg_idx_type       b2_idx_ff;
   logic [bamv_pkg::PROD_W-1:0] b2_t_ff;

   // b3: divide by the segment span through its reciprocal
   localparam int unsigned RP_W = bamv_pkg::PROD_W + bamv_pkg::RECIP_W;
   logic                        b3_ok_ff, b3_lo_ff, b3_hi_ff;
   logic [MW-1:0]               b3_mv_ff;
   bamv_pkg::seg_idx_type       b3_idx_ff;
   logic [bamv_pkg::FRAC_W-1:0] b3_q_ff;
   logic [RP_W-1:0]             b3_prod_in;

   assign b3_prod_in = RP_W'(b2_t_ff) * RP_W'(bamv_pkg::seg_recip(b2_idx_ff));

   // b4: output register
   logic          b4_ok_ff;
   logic [MW-1:0] b4_mv_ff;
   logic [PW-1:0] b4_pct_ff;
   logic [PW-1:0] b4_pct_in;

   always_comb begin
      if (!b3_ok_ff || b3_lo_ff) begin
         b4_pct_in = '0;
      end else if (b3_hi_ff) begin
         b4_pct_in = bamv_pkg::PCT_FULL;
      end else begin
         b4_pct_in = bamv_pkg::seg_base_pct(b3_idx_ff) + PW'(b3_q_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en_b[0]) begin
         b0_ok_ff <= div_side.ok;
         b0_mv_ff <= b0_mv_in;
      end
      if (en_b[1]) begin
         b1_ok_ff  <= b0_ok_ff;
         b1_mv_ff  <= b0_mv_ff;
         b1_lo_ff  <= (b0_mv_ff < bamv_pkg::CURVE_MV_LO);
         b1_hi_ff  <= (b0_mv_ff >= bamv_pkg::CURVE_MV_HI);
         b1_idx_ff <= b1_idx_in;
         b1_off_ff <= b1_diff_in[bamv_pkg::OFF_W-1:0];
      end
      if (en_b[2]) begin
         b2_ok_ff  <= b1_ok_ff;
         b2_mv_ff  <= b1_mv_ff;
         b2_lo_ff  <= b1_lo_ff;
         b2_hi_ff  <= b1_hi_ff;
         b2_idx_ff <= b1_idx_ff;
         b2_t_ff   <= bamv_pkg::PROD_W'(b1_off_ff) *
                      bamv_pkg::PROD_W'(bamv_pkg::seg_dp(b1_idx_ff));
      end
      if (en_b[3]) begin
         b3_ok_ff  <= b2_ok_ff;
         b3_mv_ff  <= b2_mv_ff;
         b3_lo_ff  <= b2_lo_ff;
         b3_hi_ff  <= b2_hi_ff;
         b3_idx_ff <= b2_idx_ff;
         b3_q_ff   <= b3_prod_in[bamv_pkg::RECIP_SHIFT +: bamv_pkg::FRAC_W];
      end
      if (en_b[4]) begin
         b4_ok_ff  <= b3_ok_ff;
         b4_mv_ff  <= b3_mv_ff;
         b4_pct_ff <= b4_pct_in;
      end
   end

   assign rsp_valid          = b_v_ff[BACK_N-1];
   assign rsp_valid_res      = b4_ok_ff;
   assign rsp_millivolts     = b4_mv_ff;
   assign rsp_charge_percent = b4_pct_ff;

endmodule
